>>> sv/tea16_pkg.sv
package tea16_pkg;

  // cipher constants
  localparam logic [31:0] TEA16_DELTA  = 32'h9e3779b9;
  localparam int          TEA16_ROUNDS = 16;
  localparam logic [3:0]  CHUNK_BYTES  = 4'd8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ENABLE = 3'd4
  } tea16_reg_t;

  // payload carried along the cell chain
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [3:0]  count;
    logic [2:0]  clear;
    logic        enc;
  } tea16_item_t;

  // tea round function of one half
  function automatic logic [31:0] tea16_mix(input logic [31:0] y, input logic [31:0] ka,
                                            input logic [31:0] kb, input logic [31:0] acc);
    tea16_mix = ((y << 4) + ka) ^ (y + acc) ^ ((y >> 5) + kb);
  endfunction

endpackage

>>> sv/tea16_if.sv
// input chunk channel
interface tea16_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_lo;
  logic [31:0] block_hi;
  logic [3:0]  byte_count;

  modport source (output valid, block_lo, block_hi, byte_count, input ready);
  modport sink   (input valid, block_lo, block_hi, byte_count, output ready);
endinterface

// result channel
interface tea16_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_lo;
  logic [31:0] out_hi;
  logic [3:0]  out_count;
  logic [2:0]  clear_count;

  modport source (output valid, out_lo, out_hi, out_count, clear_count, input ready);
  modport sink   (input valid, out_lo, out_hi, out_count, clear_count, output ready);
endinterface

// register write channel
interface tea16_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tea16_cell.sv
module tea16_cell
  import tea16_pkg::*;
#(
  parameter bit          ODD = 1'b0,
  parameter logic [31:0] ACC = TEA16_DELTA
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [31:0] ka,
  input  logic [31:0] kb,
  input  logic        in_valid,
  input  tea16_item_t in_item,
  output logic        out_valid,
  output tea16_item_t out_item
);

  logic [31:0] mix_src;
  logic [31:0] upd;
  tea16_item_t item_next;

  // one half round on encrypted items (others pass unchanged): even cells update lo from hi, odd cells hi from lo
  always_comb begin
    mix_src   = ODD ? in_item.lo : in_item.hi;
    upd       = (ODD ? in_item.hi : in_item.lo) + tea16_mix(mix_src, ka, kb, ACC);
    item_next = in_item;
    if (in_item.enc) begin
      if (ODD) begin
        item_next.hi = upd;
      end else begin
        item_next.lo = upd;
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

>>> sv/tea16_block_encryptor.sv
// throughput: one item per cycle unless the output stalls, set by a chain of 2*ROUNDS half-round cells
// the last cell register is the output register; the whole chain stalls while a finished
// item waits at the output and is not taken, with or without bubbles further up
// reset (rst, synchronous): empties the chain, clears the key words and the enable
module tea16_block_encryptor
  import tea16_pkg::*;
#(
  parameter int ROUNDS = TEA16_ROUNDS
) (
  input logic        clk,
  input logic        rst,
  tea16_in_if.sink   din,
  tea16_out_if.source dout,
  tea16_cfg_if.sink  cfg
);

  localparam int CELLS = 2 * ROUNDS;

  logic [31:0] key0;
  logic [31:0] key1;
  logic [31:0] key2;
  logic [31:0] key3;
  logic        enable;

  logic        advance;
  tea16_item_t head;
  logic        cell_valid [CELLS];
  tea16_item_t cell_item  [CELLS];

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0   <= '0;
      key1   <= '0;
      key2   <= '0;
      key3   <= '0;
      enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY0:   key0   <= cfg.data;
        REG_KEY1:   key1   <= cfg.data;
        REG_KEY2:   key2   <= cfg.data;
        REG_KEY3:   key3   <= cfg.data;
        REG_ENABLE: enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // whole chain moves unless a finished item waits at the output
  assign advance   = !cell_valid[CELLS-1] || dout.ready;
  assign din.ready = advance;

  // classify the incoming item
  always_comb begin
    head.lo    = din.block_lo;
    head.hi    = din.block_hi;
    head.count = din.byte_count;
    head.enc   = enable && (din.byte_count >= CHUNK_BYTES);
    head.clear = (enable && (din.byte_count < CHUNK_BYTES)) ? din.byte_count[2:0] : 3'd0;
  end

  // chain of half-round cells
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam bit          CELL_ODD = 1'(i % 2);
    localparam logic [31:0] CELL_ACC = 32'(64'(TEA16_DELTA) * 64'((i / 2) + 1));

    logic        prev_valid;
    tea16_item_t prev_item;

    if (i == 0) begin : g_first
      assign prev_valid = din.valid;
      assign prev_item  = head;
    end else begin : g_rest
      assign prev_valid = cell_valid[i-1];
      assign prev_item  = cell_item[i-1];
    end

    tea16_cell #(
      .ODD (CELL_ODD),
      .ACC (CELL_ACC)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ka        (CELL_ODD ? key2 : key0),
      .kb        (CELL_ODD ? key3 : key1),
      .in_valid  (prev_valid),
      .in_item   (prev_item),
      .out_valid (cell_valid[i]),
      .out_item  (cell_item[i])
    );
  end

  // result from the last cell
  assign dout.valid       = cell_valid[CELLS-1];
  assign dout.out_lo      = cell_item[CELLS-1].lo;
  assign dout.out_hi      = cell_item[CELLS-1].hi;
  assign dout.out_count   = cell_item[CELLS-1].count;
  assign dout.clear_count = cell_item[CELLS-1].clear;

  // a clear tail reports its own byte count
  a_clear_matches_count: assert property (@(posedge clk) disable iff (rst)
    dout.valid && (dout.clear_count != 3'd0) |-> dout.out_count == {1'b0, dout.clear_count})
    else $error("clear_count disagrees with out_count");

  // an encrypted item never reports clear bytes
  a_enc_no_clear: assert property (@(posedge clk) disable iff (rst)
    dout.valid && cell_item[CELLS-1].enc |-> dout.clear_count == 3'd0)
    else $error("encrypted item reports clear bytes");

  // a held result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |-> !din.ready)
    else $error("input taken while output stalled");

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dout.valid)
    else $error("result valid right after reset");

endmodule
